FILE: rtl/lr_pkg.sv
// lr_pkg: shared types and codes for the line rasterizer.
// Used by lr_front (command classification) and lr_back (command execution).
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

  // input item mode field
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // command operation carried from front to back
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

endpackage

`default_nettype wire

FILE: rtl/lr_front.sv
// lr_front: classifies input items and precomputes the line setup for loads.
// Depends on lr_pkg for the mode and operation codes.
`timescale 1ns / 1ps
`default_nettype none

module lr_front #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  in_mode,
  input  wire logic [COORD_BITS-1:0] in_start_x,
  input  wire logic [COORD_BITS-1:0] in_start_y,
  input  wire logic [COORD_BITS-1:0] in_end_x,
  input  wire logic [COORD_BITS-1:0] in_end_y,
  output logic [7*COORD_BITS+4:0]    cmd_o
);

  typedef struct packed {
    lr_pkg::op_t                op;
    logic [COORD_BITS-1:0]      start_x;
    logic [COORD_BITS-1:0]      start_y;
    logic [COORD_BITS-1:0]      end_x;
    logic [COORD_BITS-1:0]      end_y;
    logic [COORD_BITS-1:0]      span_x;
    logic [COORD_BITS-1:0]      span_y;
    logic                       x_down;
    logic                       y_down;
    logic signed [COORD_BITS+1:0] err;
  } cmd_t;

  cmd_t cmd;
  logic x_up;
  logic y_up;

  always_comb begin
    x_up = in_start_x < in_end_x;
    y_up = in_start_y < in_end_y;
    cmd.op      = (in_mode == lr_pkg::MODE_LOAD) ? lr_pkg::OP_LOAD : lr_pkg::OP_STEP;
    cmd.start_x = in_start_x;
    cmd.start_y = in_start_y;
    cmd.end_x   = in_end_x;
    cmd.end_y   = in_end_y;
    cmd.span_x  = x_up ? (in_end_x - in_start_x) : (in_start_x - in_end_x);
    cmd.span_y  = y_up ? (in_end_y - in_start_y) : (in_start_y - in_end_y);
    cmd.x_down  = !x_up;
    cmd.y_down  = !y_up;
    cmd.err     = $signed({2'b00, cmd.span_x}) - $signed({2'b00, cmd.span_y});
  end

  assign cmd_o = cmd;

endmodule

`default_nettype wire

FILE: rtl/lr_queue.sv
// lr_queue: two-entry command queue between the front and the back.
// Standalone; payload width is a parameter.
`timescale 1ns / 1ps
`default_nettype none

module lr_queue #(
  parameter int WIDTH = 89
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  valid
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = count_r == 2'd2;
  assign valid    = count_r != 2'd0;
  assign pop_data = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop)      count_r <= count_r + 2'd1;
      else if (do_pop && !do_push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

FILE: rtl/lr_back.sv
// lr_back: Bresenham stepping engine with a one-entry result register.
// Depends on lr_pkg for the operation codes; fed by lr_queue.
`timescale 1ns / 1ps
`default_nettype none

module lr_back #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cmd_valid,
  input  wire logic [7*COORD_BITS+4:0] cmd_i,
  output logic                       cmd_pop,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic [COORD_BITS-1:0]      out_pixel_x,
  output logic [COORD_BITS-1:0]      out_pixel_y,
  output logic                       out_last_pixel
);

  localparam logic [COORD_BITS-1:0] COORD_ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

  typedef struct packed {
    lr_pkg::op_t                op;
    logic [COORD_BITS-1:0]      start_x;
    logic [COORD_BITS-1:0]      start_y;
    logic [COORD_BITS-1:0]      end_x;
    logic [COORD_BITS-1:0]      end_y;
    logic [COORD_BITS-1:0]      span_x;
    logic [COORD_BITS-1:0]      span_y;
    logic                       x_down;
    logic                       y_down;
    logic signed [COORD_BITS+1:0] err;
  } cmd_t;

  cmd_t                         cmd;
  logic [COORD_BITS-1:0]        cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic [COORD_BITS-1:0]        span_x_r, span_y_r;
  logic                         x_down_r, y_down_r, busy_r;
  logic signed [COORD_BITS+1:0] err_r;
  logic                         out_valid_r;
  logic [COORD_BITS-1:0]        pix_x_r, pix_y_r;
  logic                         last_r;

  logic                         slot_free;
  logic                         do_load;
  logic                         do_emit;
  logic                         at_goal;
  logic signed [COORD_BITS+2:0] e2;
  logic signed [COORD_BITS+2:0] dxs;
  logic signed [COORD_BITS+2:0] dys;
  logic                         move_x;
  logic                         move_y;
  logic signed [COORD_BITS+2:0] err_nxt;

  assign cmd       = cmd_i;
  assign slot_free = !out_valid_r || out_pop;

  always_comb begin
    unique case (cmd.op)
      lr_pkg::OP_LOAD: cmd_pop = cmd_valid;
      lr_pkg::OP_STEP: cmd_pop = cmd_valid && (!busy_r || slot_free);
      default:         cmd_pop = 1'b0;
    endcase
  end

  assign do_load = cmd_pop && (cmd.op == lr_pkg::OP_LOAD);
  assign do_emit = cmd_pop && (cmd.op == lr_pkg::OP_STEP) && busy_r;
  assign at_goal = (cur_x_r == goal_x_r) && (cur_y_r == goal_y_r);

  always_comb begin
    e2      = {err_r, 1'b0};
    dxs     = $signed({3'b000, span_x_r});
    dys     = $signed({3'b000, span_y_r});
    move_x  = e2 > -dys;
    move_y  = e2 < dxs;
    err_nxt = {err_r[COORD_BITS+1], err_r};
    if (move_x) err_nxt = err_nxt - dys;
    if (move_y) err_nxt = err_nxt + dxs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      goal_x_r <= '0;
      goal_y_r <= '0;
      span_x_r <= '0;
      span_y_r <= '0;
      x_down_r <= 1'b0;
      y_down_r <= 1'b0;
      err_r    <= '0;
      busy_r   <= 1'b0;
    end else if (do_load) begin
      cur_x_r  <= cmd.start_x;
      cur_y_r  <= cmd.start_y;
      goal_x_r <= cmd.end_x;
      goal_y_r <= cmd.end_y;
      span_x_r <= cmd.span_x;
      span_y_r <= cmd.span_y;
      x_down_r <= cmd.x_down;
      y_down_r <= cmd.y_down;
      err_r    <= cmd.err;
      busy_r   <= 1'b1;
    end else if (do_emit) begin
      if (at_goal) begin
        busy_r <= 1'b0;
      end else begin
        err_r <= err_nxt[COORD_BITS+1:0];
        if (move_x) cur_x_r <= x_down_r ? cur_x_r - COORD_ONE : cur_x_r + COORD_ONE;
        if (move_y) cur_y_r <= y_down_r ? cur_y_r - COORD_ONE : cur_y_r + COORD_ONE;
      end
    end
  end

  // result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      pix_x_r <= cur_x_r;
      pix_y_r <= cur_y_r;
      last_r  <= at_goal;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_pixel_x    = pix_x_r;
  assign out_pixel_y    = pix_y_r;
  assign out_last_pixel = last_r;

endmodule

`default_nettype wire

FILE: rtl/line_rasterizer.sv
// line_rasterizer: all-octant Bresenham line generator, top level.
// Instantiates lr_front, lr_queue and lr_back; uses lr_pkg.
//
// Usage:
//   Input channel (push/full): each item has a mode. Mode load latches a
//   new line from start and end coordinates and gives no result; it drops
//   any line in progress. Mode step asks for the next pixel: while a line is
//   active it gives one result, otherwise nothing.
//   Result channel (empty/pop): pixel x, pixel y and last_pixel, which marks
//   the line end point; after it the line is finished and steps give nothing.
//   Path: an accepted step is classified and written into the command queue,
//   then the step engine takes it from the queue into the result register.
//   Throughput: one item per cycle while no result waits unpopped (a waiting
//   result stalls steps of an active line, not loads); a load followed by
//   steps runs without bubbles.
//   Stall: while a result waits, the two-entry command queue keeps taking
//   items; full rises once two items wait in the queue behind the held result.
//   Reset: synchronous, active low; empties the queue and result register and
//   leaves the engine idle with all line state at zero.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  in_mode,
  input  wire logic [COORD_BITS-1:0] in_start_x,
  input  wire logic [COORD_BITS-1:0] in_start_y,
  input  wire logic [COORD_BITS-1:0] in_end_x,
  input  wire logic [COORD_BITS-1:0] in_end_y,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [COORD_BITS-1:0]      out_pixel_x,
  output logic [COORD_BITS-1:0]      out_pixel_y,
  output logic                       out_last_pixel
);

  localparam int CMD_W = 7 * COORD_BITS + 5;

  logic [CMD_W-1:0] front_cmd;
  logic [CMD_W-1:0] queue_cmd;
  logic             queue_valid;
  logic             queue_pop;

  lr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_mode    (in_mode),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .cmd_o      (front_cmd)
  );

  lr_queue #(.WIDTH(CMD_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_cmd),
    .full      (full),
    .pop       (queue_pop),
    .pop_data  (queue_cmd),
    .valid     (queue_valid)
  );

  lr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (queue_valid),
    .cmd_i          (queue_cmd),
    .cmd_pop        (queue_pop),
    .out_empty      (empty),
    .out_pop        (pop),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

endmodule

`default_nettype wire

FILE: rtl/line_rasterizer_checker.sv
// line_rasterizer_checker: port-level assertions for line_rasterizer.
// Sees only the top-level ports; attached by the bind at the end of this file.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_checker #(
  parameter int COORD_BITS = 12
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  push,
  input wire logic                  full,
  input wire logic                  empty,
  input wire logic                  pop,
  input wire logic [COORD_BITS-1:0] out_pixel_x,
  input wire logic [COORD_BITS-1:0] out_pixel_y,
  input wire logic                  out_last_pixel
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

  // reset empties the command queue
  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input full after reset");

  // the command queue cannot fill without an accepted item
  a_result_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !full && !(push && !full)) ##1 (!push) |=> !full)
    else $error("queue filled without input");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_pixel_x) && $stable(out_pixel_y)
                          && $stable(out_last_pixel)))
    else $error("stalled result changed");

endmodule

bind line_rasterizer line_rasterizer_checker #(.COORD_BITS(COORD_BITS)) u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .out_pixel_x    (out_pixel_x),
  .out_pixel_y    (out_pixel_y),
  .out_last_pixel (out_last_pixel)
);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for line_rasterizer: drives load and step items into the queue
// interface and checks every pixel against a cycle-free line predictor kept in step with it.
// Depends on lr_pkg and the line_rasterizer RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int CW = 12;
  localparam int CMAX = (1 << CW) - 1;
  localparam int N_RANDOM = 1250;

  typedef struct packed {
    lr_pkg::op_t   op;
    logic [CW-1:0] start_x;
    logic [CW-1:0] start_y;
    logic [CW-1:0] end_x;
    logic [CW-1:0] end_y;
    logic          drain_first;
  } line_cmd_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  line_cmd_t cmd_on_bus = '0;
  logic full, empty, out_last_pixel;
  logic [CW-1:0] out_pixel_x, out_pixel_y;

  line_cmd_t pending_cmds[$];
  pixel_t    pixels_due[$];

  // predictor copy of the line state
  logic [CW-1:0]      cur_x, cur_y, goal_x, goal_y, span_x, span_y;
  logic               x_down, y_down, drawing;
  logic signed [CW+1:0] err_term;

  int n_total, n_accepted, n_loads, n_idle_steps, n_pixels, n_lines, n_fail;
  int gap_left, burst_left, rx_mode, rx_left;

  line_rasterizer #(.COORD_BITS(CW)) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_mode       (cmd_on_bus.op),
    .in_start_x    (cmd_on_bus.start_x),
    .in_start_y    (cmd_on_bus.start_y),
    .in_end_x      (cmd_on_bus.end_x),
    .in_end_y      (cmd_on_bus.end_y),
    .empty         (empty),
    .pop           (pop),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_last_pixel(out_last_pixel)
  );

  always #1 clk = ~clk;

  // Advance the predicted line by one accepted item.
  task automatic rasterize(input line_cmd_t cmd);
    pixel_t px;
    int     e2;
    if (cmd.op == lr_pkg::OP_LOAD) begin
      cur_x    = cmd.start_x;
      cur_y    = cmd.start_y;
      goal_x   = cmd.end_x;
      goal_y   = cmd.end_y;
      span_x   = (cmd.end_x > cmd.start_x) ? cmd.end_x - cmd.start_x : cmd.start_x - cmd.end_x;
      span_y   = (cmd.end_y > cmd.start_y) ? cmd.end_y - cmd.start_y : cmd.start_y - cmd.end_y;
      x_down   = !(cmd.start_x < cmd.end_x);
      y_down   = !(cmd.start_y < cmd.end_y);
      err_term = (CW+2)'(int'(span_x) - int'(span_y));
      drawing  = 1'b1;
      n_loads++;
    end else if (!drawing) begin
      n_idle_steps++;
    end else begin
      px.x    = cur_x;
      px.y    = cur_y;
      px.last = (cur_x == goal_x) && (cur_y == goal_y);
      pixels_due.push_back(px);
      if (px.last) begin
        drawing = 1'b0;
      end else begin
        e2 = 2 * int'(err_term);
        if (e2 > -int'(span_y)) begin
          err_term = (CW+2)'(int'(err_term) - int'(span_y));
          cur_x    = x_down ? cur_x - CW'(1) : cur_x + CW'(1);
        end
        if (e2 < int'(span_x)) begin
          err_term = (CW+2)'(int'(err_term) + int'(span_x));
          cur_y    = y_down ? cur_y - CW'(1) : cur_y + CW'(1);
        end
      end
    end
  endtask

  function automatic void queue_cmd(lr_pkg::op_t op, int sx, int sy, int ex, int ey, bit drain);
    line_cmd_t c;
    c.op          = op;
    c.start_x     = sx[CW-1:0];
    c.start_y     = sy[CW-1:0];
    c.end_x       = ex[CW-1:0];
    c.end_y       = ey[CW-1:0];
    c.drain_first = drain;
    pending_cmds.push_back(c);
  endfunction

  // Step items carry junk coordinates; the block must ignore them.
  function automatic void queue_steps(int n);
    for (int i = 0; i < n; i++)
      queue_cmd(lr_pkg::OP_STEP, $urandom_range(0, CMAX), $urandom_range(0, CMAX),
                $urandom_range(0, CMAX), $urandom_range(0, CMAX), 1'b0);
  endfunction

  function automatic void queue_line(int sx, int sy, int ex, int ey, int steps, bit drain);
    queue_cmd(lr_pkg::OP_LOAD, sx, sy, ex, ey, drain);
    queue_steps(steps);
  endfunction

  function automatic int nudge(int c, int reach);
    int d;
    d = $urandom_range(0, reach);
    if ($urandom_range(0, 1)) d = -d;
    if (c + d < 0 || c + d > CMAX) d = -d;
    return c + d;
  endfunction

  function automatic int pixel_count(int sx, int sy, int ex, int ey);
    int ax, ay;
    ax = (ex > sx) ? ex - sx : sx - ex;
    ay = (ey > sy) ? ey - sy : sy - ey;
    return ((ax > ay) ? ax : ay) + 1;
  endfunction

  // Sender: bursts of items with random gaps; hold an item while full is high.
  always @(posedge clk) begin : drive_cmds
    logic      next_push;
    line_cmd_t next_cmd;
    next_push = 1'b0;
    next_cmd  = cmd_on_bus;
    if (rst_n) begin
      if (push && !full) begin
        rasterize(cmd_on_bus);
        n_accepted++;
      end
      if (push && full) begin
        next_push = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cmds.size() > 0 &&
                   !(pending_cmds[0].drain_first && pixels_due.size() > 0)) begin
        next_cmd  = pending_cmds.pop_front();
        next_push = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    push       <= next_push;
    cmd_on_bus <= next_cmd;
  end

  // Receiver: compare each popped pixel with the oldest prediction; pop on a shifting pattern.
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    logic   next_pop;
    next_pop = 1'b0;
    if (rst_n) begin
      if (pop && !empty) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel x=%0d y=%0d last=%0b", out_pixel_x, out_pixel_y,
                 out_last_pixel);
          n_fail++;
        end else begin
          want = pixels_due.pop_front();
          n_pixels++;
          if (want.last) n_lines++;
          if (out_pixel_x !== want.x) begin
            $error("pixel_x: expected %0d, got %0d", want.x, out_pixel_x);
            n_fail++;
          end
          if (out_pixel_y !== want.y) begin
            $error("pixel_y: expected %0d, got %0d", want.y, out_pixel_y);
            n_fail++;
          end
          if (out_last_pixel !== want.last) begin
            $error("last_pixel: expected %0b, got %0b", want.last, out_last_pixel);
            n_fail++;
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(50, 300);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: next_pop = 1'b1;
        1: next_pop = $urandom_range(0, 1);
        2: next_pop = ($urandom_range(0, 5) == 0);
        default: next_pop = ((rx_left / 8) % 2 == 0);
      endcase
    end
    pop <= next_pop;
  end

  initial begin : run
    int  n_directed, last_drain, pick, sx, sy, ex, ey, reach, len, extra;
    bit  drain;

    // directed: idle step, single-pixel line, extremes, load while busy, flat axis
    queue_steps(1);
    queue_line(0, 0, 0, 0, 2, 1'b0);
    queue_line(CMAX, 0, CMAX - 3, 3, 4, 1'b0);
    queue_line(0, CMAX, 2, CMAX - 5, 6, 1'b0);
    queue_line(0, 0, CMAX, CMAX, 2, 1'b0);
    queue_line(CMAX, CMAX, CMAX, CMAX - 1, 2, 1'b0);
    n_directed = pending_cmds.size();
    last_drain = 0;

    while (pending_cmds.size() < n_directed + N_RANDOM) begin
      pick  = $urandom_range(0, 99);
      drain = (pending_cmds.size() == n_directed) || (pending_cmds.size() - last_drain > 300);
      if (drain) last_drain = pending_cmds.size();
      sx = $urandom_range(0, CMAX);
      sy = $urandom_range(0, CMAX);
      if (pick < 75) begin
        reach = (pick < 65) ? 12 : 60;
        ex    = nudge(sx, reach);
        ey    = nudge(sy, reach);
        len   = pixel_count(sx, sy, ex, ey);
        extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        queue_line(sx, sy, ex, ey, len + extra, drain);
      end else if (pick < 93) begin
        // abandoned line: arbitrary endpoints, cut short by the next load
        ex = $urandom_range(0, CMAX);
        ey = $urandom_range(0, CMAX);
        queue_line(sx, sy, ex, ey, $urandom_range(0, 8), drain);
      end else begin
        queue_cmd(lr_pkg::OP_STEP, sx, sy, $urandom_range(0, CMAX), $urandom_range(0, CMAX),
                  drain);
        queue_steps($urandom_range(0, 3));
      end
    end
    n_total = pending_cmds.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total) @(posedge clk);
    while (pixels_due.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (pixels_due.size() > 0) begin
      $error("%0d predicted pixels never arrived", pixels_due.size());
      n_fail++;
    end
    $display("Ran %0d items: %0d line loads, %0d steps with no line active.",
             n_accepted, n_loads, n_idle_steps);
    $display("Checked %0d pixels, %0d of them line end points.", n_pixels, n_lines);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
